// File: design/stscn_pkg.sv
// Shared types and result codes of the source token scanner.
`default_nettype none
package stscn_pkg;

  // Token kinds
  localparam logic [3:0] K_NUMBER  = 4'd0;
  localparam logic [3:0] K_NAME    = 4'd1;
  localparam logic [3:0] K_TYPE    = 4'd2;
  localparam logic [3:0] K_FUNC    = 4'd3;
  localparam logic [3:0] K_BRACKET = 4'd4;
  localparam logic [3:0] K_STRING  = 4'd5;
  localparam logic [3:0] K_ASSIGN  = 4'd6;
  localparam logic [3:0] K_DONE    = 4'd7;
  localparam logic [3:0] K_ERROR   = 4'd8;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NUM_ALPHA = 3'd1;
  localparam logic [2:0] ERR_OPEN_BRK  = 3'd2;
  localparam logic [2:0] ERR_OPEN_STR  = 3'd3;
  localparam logic [2:0] ERR_BAD_CHAR  = 3'd4;

  // Most results one byte can cause
  localparam int MAX_RES = 3;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [2:0]  error_code;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        final_res;
  } out_item_t;

  // Results of one byte, slot 0 first
  typedef struct packed {
    logic [1:0]                cnt;
    out_item_t [MAX_RES-1:0]   item;
  } batch_t;

endpackage
`default_nettype wire

// File: design/source_token_scanner.sv
// Top level of the source token scanner: input register, scan core, result buffer.
//
// Usage:
//   in_valid/in_stall/in_data carry one source byte per transfer, with
//   end_of_input set on the final byte of a source. out_valid/out_stall/
//   out_data carry token results: kind, error code, start offset, length,
//   line, and final_res on the closing done result of each source.
//   Path: a byte waits in the input register, is scanned by the core as it
//   moves into the result buffer, and its first result is offered on out_data.
//   Throughput: one byte per cycle while out_stall is low and each byte
//   causes at most one result. A byte that causes k results (k up to 3)
//   holds the input until all k have left, as the result buffer hands out
//   one result per transfer. Bytes with no result leave no later byte held.
//   Reset (rst_n low, synchronous) empties the input register and result
//   buffer and returns the scanner to idle at offset 0, line 1. After each
//   done result the scanner restarts the same way.
//   When the receiver stalls, the current result holds steady; the input
//   register keeps one byte and in_stall rises once it cannot move on.
`default_nettype none
module source_token_scanner #(
  parameter int OFFSET_BITS = 16,
  parameter int LINE_BITS   = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  stscn_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output stscn_pkg::out_item_t out_data
);
  import stscn_pkg::*;

  in_item_t in_r;
  logic     in_vld_r;
  logic     buf_ready;
  logic     advance;
  batch_t   batch;

  // Byte in the input register moves into the scan core when the buffer frees
  assign advance  = in_vld_r && buf_ready;
  assign in_stall = in_vld_r && !buf_ready;

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  stscn_core #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (in_r),
    .fire  (advance),
    .batch (batch)
  );

  stscn_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .batch     (batch),
    .load      (advance),
    .ready     (buf_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Only the done result closes a source
  a_final_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.final_res == (out_data.kind == K_DONE)))
    else $error("final_res does not match done kind");

  // Error code is set exactly on error results
  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.error_code != ERR_NONE) == (out_data.kind == K_ERROR)))
    else $error("error code and kind disagree");

  // Input only stalls with a byte held
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r)
    else $error("input stalled with empty register");

  // A scanned byte that ends the source always leaves a result behind
  a_eoi_result: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_r.end_of_input) |=> out_valid)
    else $error("end of input produced no result");

endmodule
`default_nettype wire

// File: design/stscn_core.sv
// Per-byte scan state machine: scanner state and result generation.
`default_nettype none
module stscn_core #(
  parameter int OFFSET_BITS = 16,
  parameter int LINE_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  stscn_pkg::in_item_t item,
  input  logic               fire,
  output stscn_pkg::batch_t  batch
);
  import stscn_pkg::*;

  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_NUMBER  = 3'd1;
  localparam logic [2:0] M_NAME    = 3'd2;
  localparam logic [2:0] M_BRACKET = 3'd3;
  localparam logic [2:0] M_STRING  = 3'd4;
  localparam logic [2:0] M_ERROR   = 3'd5;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_USCORE = 8'h5F;

  localparam logic [1:0] NK_PLAIN  = 2'd0;
  localparam logic [1:0] NK_DOLLAR = 2'd1;
  localparam logic [1:0] NK_HASH   = 2'd2;

  function automatic logic [15:0] sat16(input logic [32:0] v);
    return (|v[32:16]) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           (c == CH_USCORE);
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_QUOTE) || (c == CH_LF) || (c == CH_TAB) ||
           (c == CH_CR) || (c == CH_NUL) || (c == CH_EQ);
  endfunction

  function automatic out_item_t mk(input logic [3:0] kind, input logic [2:0] err,
                                   input logic [15:0] start, input logic [15:0] len,
                                   input logic [15:0] line, input logic fin);
    out_item_t r;
    r.kind         = kind;
    r.error_code   = err;
    r.start_offset = start;
    r.token_length = len;
    r.line_number  = line;
    r.final_res    = fin;
    return r;
  endfunction

  logic [2:0]             mode_r, mode_a, mode_nxt;
  logic [1:0]             nk_r, nk_a, nk_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_a, start_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_a, off_nxt;
  logic [LINE_BITS-1:0]   line_r, line_a, line_nxt;
  logic [OFFSET_BITS-1:0] run_len, dist_end;
  logic                   run_idle, line_inc;
  logic [1:0]             n;
  logic [15:0]            line_old16, line_new16;
  logic [7:0]             c;
  batch_t                 batch_c;

  assign c          = item.ch;
  assign run_len    = (off_r >= start_r) ? off_r - start_r : '0;
  assign line_old16 = sat16(33'(line_r));

  always_comb begin
    mode_a   = mode_r;
    nk_a     = nk_r;
    start_a  = start_r;
    run_idle = 1'b0;
    line_inc = 1'b0;
    n        = 2'd0;
    batch_c  = '0;

    // Byte handling for the current scan mode
    unique case (mode_r)
      M_NUMBER: begin
        if (is_dig(c)) begin
          mode_a = M_NUMBER;
        end else if (is_sep(c)) begin
          batch_c.item[n] = mk(K_NUMBER, ERR_NONE, sat16(33'(start_r)), sat16(33'(run_len)),
                               line_old16, 1'b0);
          n        = n + 2'd1;
          mode_a   = M_IDLE;
          run_idle = 1'b1;
        end else begin
          batch_c.item[n] = mk(K_ERROR, ERR_NUM_ALPHA, sat16(33'(off_r)), 16'd0,
                               line_old16, 1'b0);
          n      = n + 2'd1;
          mode_a = M_ERROR;
        end
      end
      M_NAME: begin
        if (is_sep(c)) begin
          batch_c.item[n] = mk(K_NAME + {2'b00, nk_r}, ERR_NONE, sat16(33'(start_r)),
                               sat16(33'(run_len)), line_old16, 1'b0);
          n        = n + 2'd1;
          mode_a   = M_IDLE;
          run_idle = 1'b1;
        end
      end
      M_BRACKET: begin
        if (c == CH_RBRK) begin
          batch_c.item[n] = mk(K_BRACKET, ERR_NONE, sat16(33'(start_r) + 33'd1),
                               (run_len == '0) ? 16'd0 : sat16(33'(run_len) - 33'd1),
                               line_old16, 1'b0);
          n      = n + 2'd1;
          mode_a = M_IDLE;
        end else if (c == CH_NUL) begin
          batch_c.item[n] = mk(K_ERROR, ERR_OPEN_BRK, sat16(33'(start_r)), 16'd0,
                               line_old16, 1'b0);
          n      = n + 2'd1;
          mode_a = M_ERROR;
        end else if (c == CH_LF) begin
          line_inc = 1'b1;
        end
      end
      M_STRING: begin
        if (c == CH_QUOTE) begin
          batch_c.item[n] = mk(K_STRING, ERR_NONE, sat16(33'(start_r)),
                               sat16(33'(run_len) + 33'd1), line_old16, 1'b0);
          n      = n + 2'd1;
          mode_a = M_IDLE;
        end else if (c == CH_NUL) begin
          batch_c.item[n] = mk(K_ERROR, ERR_OPEN_STR, sat16(33'(start_r)), 16'd0,
                               line_old16, 1'b0);
          n      = n + 2'd1;
          mode_a = M_ERROR;
        end else if (c == CH_LF) begin
          line_inc = 1'b1;
        end
      end
      M_IDLE: begin
        run_idle = 1'b1;
      end
      default: begin
        mode_a = mode_r;
      end
    endcase

    // Byte seen outside any token, also the separator that closed one
    if (run_idle) begin
      priority if ((c == CH_SPACE) || (c == CH_CR)) begin
        mode_a = M_IDLE;
      end else if (c == CH_LF) begin
        line_inc = 1'b1;
      end else if (c == CH_EQ) begin
        batch_c.item[n] = mk(K_ASSIGN, ERR_NONE, sat16(33'(off_r)), 16'd1,
                             line_old16, 1'b0);
        n = n + 2'd1;
      end else if (is_dig(c)) begin
        mode_a  = M_NUMBER;
        start_a = off_r;
      end else if (is_alpha(c) || (c == CH_DOLLAR) || (c == CH_HASH)) begin
        mode_a  = M_NAME;
        start_a = off_r;
        nk_a    = (c == CH_DOLLAR) ? NK_DOLLAR : (c == CH_HASH) ? NK_HASH : NK_PLAIN;
      end else if (c == CH_LBRK) begin
        mode_a  = M_BRACKET;
        start_a = off_r;
      end else if (c == CH_QUOTE) begin
        mode_a  = M_STRING;
        start_a = off_r;
      end else begin
        batch_c.item[n] = mk(K_ERROR, ERR_BAD_CHAR, sat16(33'(off_r)), 16'd0,
                             line_old16, 1'b0);
        n      = n + 2'd1;
        mode_a = M_ERROR;
      end
    end

    line_a = (line_inc && (line_r != '1)) ? line_r + 1'b1 : line_r;
    off_a  = (off_r != '1) ? off_r + 1'b1 : off_r;

    // Length and line as seen after this byte
    dist_end   = (off_a >= start_a) ? off_a - start_a : '0;
    line_new16 = sat16(33'(line_a));

    mode_nxt  = mode_a;
    nk_nxt    = nk_a;
    start_nxt = start_a;
    off_nxt   = off_a;
    line_nxt  = line_a;

    // End of input: pending token (or open error), then the total
    if (item.end_of_input) begin
      unique case (mode_a)
        M_NUMBER: begin
          batch_c.item[n] = mk(K_NUMBER, ERR_NONE, sat16(33'(start_a)),
                               sat16(33'(dist_end)), line_new16, 1'b0);
          n = n + 2'd1;
        end
        M_NAME: begin
          batch_c.item[n] = mk(K_NAME + {2'b00, nk_a}, ERR_NONE, sat16(33'(start_a)),
                               sat16(33'(dist_end)), line_new16, 1'b0);
          n = n + 2'd1;
        end
        M_BRACKET: begin
          batch_c.item[n] = mk(K_ERROR, ERR_OPEN_BRK, sat16(33'(start_a)), 16'd0,
                               line_new16, 1'b0);
          n = n + 2'd1;
        end
        M_STRING: begin
          batch_c.item[n] = mk(K_ERROR, ERR_OPEN_STR, sat16(33'(start_a)), 16'd0,
                               line_new16, 1'b0);
          n = n + 2'd1;
        end
        default: begin
          n = n;
        end
      endcase
      batch_c.item[n] = mk(K_DONE, ERR_NONE, sat16(33'(off_a)), 16'd0, line_new16, 1'b1);
      n = n + 2'd1;
      mode_nxt  = M_IDLE;
      nk_nxt    = NK_PLAIN;
      start_nxt = '0;
      off_nxt   = '0;
      line_nxt  = LINE_BITS'(1);
    end
    batch_c.cnt = n;
  end

  assign batch = batch_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      nk_r    <= NK_PLAIN;
      start_r <= '0;
      off_r   <= '0;
      line_r  <= LINE_BITS'(1);
    end else if (fire) begin
      mode_r  <= mode_nxt;
      nk_r    <= nk_nxt;
      start_r <= start_nxt;
      off_r   <= off_nxt;
      line_r  <= line_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/stscn_outbuf.sv
// Result buffer: holds one byte's results and hands them out one per transfer.
`default_nettype none
module stscn_outbuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  stscn_pkg::batch_t    batch,
  input  logic                 load,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output stscn_pkg::out_item_t out_data
);
  import stscn_pkg::*;

  out_item_t [MAX_RES-1:0] slot_r, slot_nxt;
  logic [1:0]              cnt_r, cnt_nxt;
  logic                    pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot_r[0];
  assign pop       = out_valid && !out_stall;
  // Free for a new batch once the last waiting result leaves
  assign ready     = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop);

  always_comb begin
    slot_nxt = slot_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      slot_nxt = batch.item;
      cnt_nxt  = batch.cnt;
    end else if (pop) begin
      slot_nxt = {slot_r[MAX_RES-1], slot_r[MAX_RES-1:1]};
      cnt_nxt  = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire
